[design/sspi_pkg.sv]
package sspi_pkg;

  localparam int unsigned CapacityDefault = 32;

  typedef enum logic [2:0] {
    FnInsFirst  = 3'd0,
    FnEraFirst  = 3'd1,
    FnInsSecond = 3'd2,
    FnEraSecond = 3'd3,
    FnIntersect = 3'd4,
    FnListFirst = 3'd5,
    FnListSecond = 3'd6,
    FnUnused    = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StNoChange = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SSeek,
    SShift,
    SList,
    SMerge,
    SOut
  } state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               has_element;
    logic [1:0]         status;
    logic               last;
  } out_beat_t;

endpackage

[design/sspi_store.sv]
module sspi_store #(
  parameter int unsigned Capacity = 32,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[design/sorted_set_pair_intersection.sv]
// channel | direction | payload    | handshake
// in      | input     | in_beat_t  | in_valid_i / in_stall_o
// out     | output     | out_beat_t | out_valid_o / out_stall_i
// insert and erase: a lower-bound scan, reading one entry per cycle, then a shift
// through the store memory
// list walks one store in order; intersect merges both stores,
// bounded by the single read port of each store memory
// one item at a time; stall on out holds the result register and the sequencer
// reset clears both counts; store contents stay undefined until written
module sorted_set_pair_intersection
  #(
  parameter int unsigned Capacity = sspi_pkg::CapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sspi_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sspi_pkg::out_beat_t out_data_o
);
  import sspi_pkg::*;

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam logic [CW-1:0] CapC = CW'(Capacity);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q [2];
  logic [CW-1:0] cnt_d [2];
  logic [2:0]    fn_q, fn_d;
  logic [31:0]   key_q, key_d;
  logic          sel_q, sel_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic          rv_q, rv_d;
  logic          any_q, any_d;
  logic [31:0]   carry_q, carry_d;
  logic          ov_q, ov_d;
  out_beat_t     ob_q, ob_d;

  logic [AW-1:0] ra [2];
  logic [31:0]   rd [2];
  logic          we [2];
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  for (genvar g = 0; g < 2; g++) begin : g_st
    sspi_store #(.Capacity(Capacity)) u_store (
      .clk_i, .we_i(we[g]), .waddr_i(wa), .wdata_i(wd),
      .raddr_i(ra[g]), .rdata_o(rd[g])
    );
  end

  logic [31:0] cur;
  logic        sfull;
  logic [CW-1:0] scnt;
  assign cur   = sel_q ? rd[1] : rd[0];
  assign scnt  = sel_q ? cnt_q[1] : cnt_q[0];
  assign sfull = scnt >= CapC;

  assign in_stall_o  = (state_q != SIdle) || ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      ov_q     <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q[0] <= cnt_d[0];
      cnt_q[1] <= cnt_d[1];
      ov_q     <= ov_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fn_q    <= fn_d;
    key_q   <= key_d;
    sel_q   <= sel_d;
    i_q     <= i_d;
    j_q     <= j_d;
    any_q   <= any_d;
    carry_q <= carry_d;
    ob_q    <= ob_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fn_d    = fn_q;
    key_d   = key_q;
    sel_d   = sel_q;
    i_d     = i_q;
    j_d     = j_q;
    rv_d    = 1'b0;
    any_d   = any_q;
    carry_d = carry_q;
    ov_d    = ov_q && out_stall_i;
    ob_d    = ob_q;
    ra[0]   = i_q[AW-1:0];
    ra[1]   = j_q[AW-1:0];
    we[0]   = 1'b0;
    we[1]   = 1'b0;
    wa      = i_q[AW-1:0];
    wd      = carry_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i && !ov_q) begin
          fn_d  = in_data_i.func;
          key_d = in_data_i.value ^ 32'h8000_0000;
          i_d   = '0;
          j_d   = '0;
          any_d = 1'b0;
          ra[0] = '0;
          ra[1] = '0;
          rv_d  = 1'b1;
          case (func_e'(in_data_i.func))
            FnInsFirst, FnEraFirst: begin
              sel_d = 1'b0; state_d = SSeek;
            end
            FnInsSecond, FnEraSecond: begin
              sel_d = 1'b1; state_d = SSeek;
            end
            FnIntersect: state_d = SMerge;
            FnListFirst: begin
              sel_d = 1'b0; state_d = SList;
            end
            FnListSecond: begin
              sel_d = 1'b1; state_d = SList;
            end
            default: begin
              ob_d = '{element: '0, has_element: 1'b0, status: StNoChange, last: 1'b1};
              ov_d = 1'b1;
            end
          endcase
        end
      end
      SSeek: begin
        // cur holds entry i when rv_q
        ra[0] = i_q[AW-1:0];
        ra[1] = i_q[AW-1:0];
        if (i_q < scnt && !rv_q) begin
          rv_d = 1'b1;
        end else if (i_q < scnt && cur < key_q) begin
          i_d   = i_q + 1'b1;
          ra[0] = AW'(i_q + 1'b1);
          ra[1] = AW'(i_q + 1'b1);
          rv_d  = 1'b1;
        end else begin
          state_d = SOut;
          ob_d = '{element: '0, has_element: 1'b0, status: StDone, last: 1'b1};
          if (!fn_q[0]) begin
            if (i_q < scnt && cur == key_q) begin
              ob_d.status = StNoChange;
            end else if (sfull) begin
              ob_d.status = StFull;
            end else begin
              carry_d = key_q;
              state_d = SShift;
              rv_d    = 1'b1;
            end
          end else begin
            if (i_q < scnt && cur == key_q) begin
              state_d = SShift;
              ra[0] = AW'(i_q + 1'b1);
              ra[1] = AW'(i_q + 1'b1);
              rv_d  = 1'b1;
            end else begin
              ob_d.status = StNoChange;
            end
          end
        end
      end
      SShift: begin
        ra[0] = i_q[AW-1:0];
        ra[1] = i_q[AW-1:0];
        if (!fn_q[0]) begin
          // insert: write carry at i, carry takes old entry i
          if (i_q >= scnt) begin
            we[sel_q] = 1'b1;
            cnt_d[sel_q] = scnt + 1'b1;
            state_d = SOut;
          end else if (!rv_q) begin
            rv_d = 1'b1;
          end else begin
            we[sel_q] = 1'b1;
            carry_d = cur;
            i_d = i_q + 1'b1;
          end
        end else begin
          // erase: entry i takes entry i+1
          ra[0] = AW'(i_q + 1'b1);
          ra[1] = AW'(i_q + 1'b1);
          if (i_q + 1'b1 >= scnt) begin
            cnt_d[sel_q] = scnt - 1'b1;
            state_d = SOut;
          end else if (!rv_q) begin
            rv_d = 1'b1;
          end else begin
            we[sel_q] = 1'b1;
            wd = cur;
            i_d = i_q + 1'b1;
            ra[0] = AW'(i_q + 2'd2);
            ra[1] = AW'(i_q + 2'd2);
          end
        end
      end
      SOut: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          state_d = SIdle;
        end
      end
      SList: begin
        ra[0] = i_q[AW-1:0];
        ra[1] = i_q[AW-1:0];
        if (!ov_q || !out_stall_i) begin
          if (i_q >= scnt) begin
            if (!any_q) begin
              ob_d = '{element: '0, has_element: 1'b0, status: StDone, last: 1'b1};
              ov_d = 1'b1;
            end
            state_d = SIdle;
          end else if (!rv_q) begin
            rv_d = 1'b1;
          end else begin
            ob_d = '{element: cur ^ 32'h8000_0000, has_element: 1'b1, status: StDone,
                     last: (i_q + 1'b1 >= scnt)};
            ov_d = 1'b1;
            any_d = 1'b1;
            i_d = i_q + 1'b1;
            ra[0] = AW'(i_q + 1'b1);
            ra[1] = AW'(i_q + 1'b1);
            rv_d = 1'b1;
          end
        end else begin
          rv_d = rv_q;
        end
      end
      SMerge: begin
        if (!ov_q || !out_stall_i) begin
          if (i_q >= cnt_q[0] || j_q >= cnt_q[1]) begin
            if (!any_q) begin
              ob_d = '{element: '0, has_element: 1'b0, status: StDone, last: 1'b1};
            end else begin
              // the held match is the last beat
              ob_d = '{element: carry_q ^ 32'h8000_0000, has_element: 1'b1,
                       status: StDone, last: 1'b1};
            end
            ov_d = 1'b1;
            state_d = SIdle;
          end else if (!rv_q) begin
            rv_d = 1'b1;
          end else if (rd[0] < rd[1]) begin
            i_d = i_q + 1'b1;
            ra[0] = AW'(i_q + 1'b1);
            rv_d = 1'b1;
          end else if (rd[0] > rd[1]) begin
            j_d = j_q + 1'b1;
            ra[1] = AW'(j_q + 1'b1);
            rv_d = 1'b1;
          end else begin
            // previous match is released, this one waits in carry for the next
            if (any_q) begin
              ob_d = '{element: carry_q ^ 32'h8000_0000, has_element: 1'b1,
                       status: StDone, last: 1'b0};
              ov_d = 1'b1;
            end
            carry_d = rd[0];
            any_d = 1'b1;
            i_d = i_q + 1'b1;
            j_d = j_q + 1'b1;
            ra[0] = AW'(i_q + 1'b1);
            ra[1] = AW'(j_q + 1'b1);
            rv_d = 1'b1;
          end
        end else begin
          rv_d = rv_q;
        end
      end
      default: state_d = SIdle;
    endcase
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CapC) && (cnt_q[1] <= CapC))
    else $error("count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(ob_q)))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != SIdle || ov_q))
    else $error("accepted beat dropped");
`endif
endmodule
